// File: hw/rtl/mkwrl_pkg.sv
// Shared types, constants and codes for the multi-key window rate limiter.
package mkwrl_pkg;

   localparam int TABLE_DEPTH_DEFAULT   = 64;
   localparam int KEY_BITS_DEFAULT      = 64;
   localparam int CLASS_ENTRIES_DEFAULT = 256;

   localparam int TIME_BITS      = 64;
   localparam int ID_BITS        = 64;
   localparam int LIMIT_BITS     = 32;
   localparam int CLASS_BITS     = 8;
   localparam int TRACKED_BITS   = 9;
   localparam int REG_INDEX_BITS = 3;
   localparam int TOTAL_SHIFT    = 2;
   localparam int OVERLOAD_SHIFT = 2;

   localparam logic [TRACKED_BITS-1:0] TRACKED_MAX = '1;

   typedef enum logic [1:0] {
      CMD_ADMIT    = 2'd0,
      CMD_OVERLOAD = 2'd1,
      CMD_CLEAR    = 2'd2,
      CMD_STATUS   = 2'd3
   } command_type;

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_WINDOW_LENGTH   = 3'd0,
      REG_TOTAL_LIMIT     = 3'd1,
      REG_ENDPOINT_LIMIT  = 3'd2,
      REG_TARGET_LIMIT    = 3'd3,
      REG_CUSTODIAN_LIMIT = 3'd4,
      REG_CLASS_LIMIT     = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_DIVIDE,
      ST_WINDOW,
      ST_SCAN,
      ST_CHECK,
      ST_APPLY,
      ST_RESPOND
   } state_type;

   typedef struct packed {
      logic [1:0]            command;
      logic [TIME_BITS-1:0]  now_seconds;
      logic [ID_BITS-1:0]    endpoint_id;
      logic [ID_BITS-1:0]    target_id;
      logic [ID_BITS-1:0]    custodian_id;
      logic [CLASS_BITS-1:0] class_id;
   } req_payload_type;

   typedef struct packed {
      logic                    admitted;
      logic                    overload_active;
      logic [TRACKED_BITS-1:0] tracked_keys;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic div_start;
      logic window;
      logic scan_start;
      logic scan_step;
      logic check;
      logic apply;
      logic respond;
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_done;
      logic window_stale;
      logic scan_done;
      logic rsp_free;
   } dp_status_type;

endpackage

// File: hw/rtl/multi_key_window_rate_limiter.sv
// Top level of the multi-key window rate limiter: controller plus datapath.
// One request is handled at a time; a result waits in an output register while the
// next request is taken. An admit runs a 64-step bit-serial divide for the window
// number, one window update, one scan of the three key memories side by side, one
// entry per cycle through registered reads, one check/update step and one response
// step. An admit from an earlier window skips the scan. Note-overload and clear run
// one apply step before the response; a status query goes straight to the response.
// A stalled result that is still waiting adds the cycles of its stall before the
// next result is written.
// Key tables need no clearing pass after reset; per-entry valid flops cover them.
module multi_key_window_rate_limiter #(
   parameter int TABLE_DEPTH   = mkwrl_pkg::TABLE_DEPTH_DEFAULT,
   parameter int KEY_BITS      = mkwrl_pkg::KEY_BITS_DEFAULT,
   parameter int CLASS_ENTRIES = mkwrl_pkg::CLASS_ENTRIES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  mkwrl_pkg::req_payload_type             req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output mkwrl_pkg::rsp_payload_type             rsp_data,
   input  logic                                   csr_write_enable,
   input  logic [mkwrl_pkg::REG_INDEX_BITS-1:0]   csr_index,
   input  logic [mkwrl_pkg::LIMIT_BITS-1:0]       csr_write_data
);
   import mkwrl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mkwrl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_data.command),
      .req_ready   (req_ready),
      .status      (status),
      .cmd         (cmd)
   );

   mkwrl_dp #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .KEY_BITS      (KEY_BITS),
      .CLASS_ENTRIES (CLASS_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

// File: hw/rtl/mkwrl_div.sv
// Bit-serial restoring divider: window number from time and window length.
module mkwrl_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mkwrl_pkg::TIME_BITS-1:0]    dividend,
   input  logic [mkwrl_pkg::LIMIT_BITS-1:0]   divisor,
   output logic                               busy,
   output logic [mkwrl_pkg::TIME_BITS-1:0]    quotient
);
   import mkwrl_pkg::*;

   localparam int CW = $clog2(TIME_BITS + 1);

   logic [CW-1:0]           count_ff, count_in;
   logic                    busy_ff, busy_in;
   logic [TIME_BITS-1:0]    quot_ff, quot_in;
   logic [LIMIT_BITS-1:0]   rem_ff, rem_in;
   logic [LIMIT_BITS:0]     rem_shift;
   logic [LIMIT_BITS:0]     rem_diff;

   assign rem_shift = {rem_ff, quot_ff[TIME_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor};

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      quot_in  = quot_ff;
      rem_in   = rem_ff;
      if (start) begin
         count_in = CW'(TIME_BITS);
         busy_in  = 1'b1;
         quot_in  = dividend;
         rem_in   = '0;
      end else if (busy_ff) begin
         if (rem_diff[LIMIT_BITS]) begin
            rem_in  = rem_shift[LIMIT_BITS-1:0];
            quot_in = {quot_ff[TIME_BITS-2:0], 1'b0};
         end else begin
            rem_in  = rem_diff[LIMIT_BITS-1:0];
            quot_in = {quot_ff[TIME_BITS-2:0], 1'b1};
         end
         count_in = count_ff - CW'(1);
         busy_in  = (count_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

endmodule

// File: hw/rtl/mkwrl_dp.sv
// Datapath: settings, window and overload state, key tables, counters, result register.
module mkwrl_dp #(
   parameter int TABLE_DEPTH   = mkwrl_pkg::TABLE_DEPTH_DEFAULT,
   parameter int KEY_BITS      = mkwrl_pkg::KEY_BITS_DEFAULT,
   parameter int CLASS_ENTRIES = mkwrl_pkg::CLASS_ENTRIES_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  mkwrl_pkg::ctrl_cmd_type                cmd,
   output mkwrl_pkg::dp_status_type              status,
   input  mkwrl_pkg::req_payload_type             req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output mkwrl_pkg::rsp_payload_type             rsp_data,
   input  logic                                   csr_write_enable,
   input  logic [mkwrl_pkg::REG_INDEX_BITS-1:0]   csr_index,
   input  logic [mkwrl_pkg::LIMIT_BITS-1:0]       csr_write_data
);
   import mkwrl_pkg::*;

   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int CAW = $clog2(CLASS_ENTRIES);
   localparam int TW  = $clog2(3 * TABLE_DEPTH + CLASS_ENTRIES + 1);
   localparam int SW  = (TW > TRACKED_BITS) ? TW : TRACKED_BITS + 1;
   localparam int MW  = KEY_BITS + LIMIT_BITS;
   localparam int NT  = 3;

   logic [LIMIT_BITS-1:0] window_length_ff, total_limit_ff, endpoint_limit_ff;
   logic [LIMIT_BITS-1:0] target_limit_ff, custodian_limit_ff, class_limit_ff;

   req_payload_type       req_ff;
   logic [TIME_BITS-1:0]  active_ff;
   logic                  seen_ff;
   logic [LIMIT_BITS-1:0] total_ff;
   logic [TIME_BITS-1:0]  deadline_ff;
   logic                  admitted_ff;
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_ff;

   logic [AW:0]           idx_ff;
   logic [AW-1:0]         rd_idx_ff;
   logic                  rd_vld_ff;

   logic [LIMIT_BITS-1:0] len;
   logic                  div_busy;
   logic [TIME_BITS-1:0]  quotient;
   logic                  stale;
   logic                  clear_all;
   logic                  clear_win;
   logic                  take;
   logic                  overload_now;
   logic [LIMIT_BITS-1:0] eff_total;
   logic                  allow_all;

   logic [KEY_BITS-1:0]   key_sel   [NT];
   logic [LIMIT_BITS-1:0] limit_sel [NT];
   logic                  allow_t   [NT];
   logic [AW:0]           tcount    [NT];

   logic [CAW-1:0]        cls_idx;
   logic                  cls_in_range;
   logic [LIMIT_BITS-1:0] cls_mem [CLASS_ENTRIES];
   logic [LIMIT_BITS-1:0] cls_rdata_ff;
   logic [CLASS_ENTRIES-1:0] cls_valid_ff;
   logic [CAW:0]          cls_count_ff;
   logic [LIMIT_BITS-1:0] cls_used;
   logic                  cls_ok;

   logic [LIMIT_BITS+OVERLOAD_SHIFT-1:0] span;
   logic [TIME_BITS:0]    until_sum;
   logic [TIME_BITS-1:0]  until_sat;
   logic [SW-1:0]         tracked_sum;
   logic [TRACKED_BITS-1:0] tracked;

   assign len = (window_length_ff == '0) ? LIMIT_BITS'(1) : window_length_ff;

   mkwrl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (req_ff.now_seconds),
      .divisor  (len),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign stale     = seen_ff && (quotient < active_ff);
   assign clear_all = cmd.apply && (command_type'(req_ff.command) == CMD_CLEAR);
   assign clear_win = cmd.window && seen_ff && (quotient > active_ff);

   assign key_sel[0]   = req_ff.endpoint_id[KEY_BITS-1:0];
   assign key_sel[1]   = req_ff.target_id[KEY_BITS-1:0];
   assign key_sel[2]   = req_ff.custodian_id[KEY_BITS-1:0];
   assign limit_sel[0] = endpoint_limit_ff;
   assign limit_sel[1] = target_limit_ff;
   assign limit_sel[2] = custodian_limit_ff;

   assign overload_now = deadline_ff > req_ff.now_seconds;
   always_comb begin
      eff_total = total_limit_ff;
      if (overload_now) begin
         eff_total = total_limit_ff >> TOTAL_SHIFT;
         if (eff_total == '0) begin
            eff_total = LIMIT_BITS'(1);
         end
      end
   end

   assign cls_in_range = {1'b0, req_ff.class_id} < (CLASS_BITS + 1)'(CLASS_ENTRIES);
   assign cls_idx      = CAW'(req_ff.class_id);
   assign cls_used     = cls_valid_ff[cls_idx] ? cls_rdata_ff : '0;
   assign cls_ok       = cls_in_range && (class_limit_ff != '0) && (cls_used < class_limit_ff);

   assign allow_all = (total_ff < eff_total) && allow_t[0] && allow_t[1] && allow_t[2] && cls_ok;
   assign take      = cmd.check && allow_all;

   for (genvar t = 0; t < NT; t++) begin : g_table
      logic [MW-1:0]          mem [TABLE_DEPTH];
      logic [MW-1:0]          rdata_ff;
      logic [TABLE_DEPTH-1:0] valid_ff;
      logic [AW:0]            count_ff;
      logic                   hit_ff;
      logic                   free_ff;
      logic [AW-1:0]          hit_slot_ff;
      logic [AW-1:0]          free_slot_ff;
      logic [LIMIT_BITS-1:0]  hit_cnt_ff;
      logic [AW-1:0]          slot;
      logic [LIMIT_BITS-1:0]  used;

      assign slot       = hit_ff ? hit_slot_ff : free_slot_ff;
      assign used       = hit_ff ? hit_cnt_ff : '0;
      assign allow_t[t] = (hit_ff || free_ff) && (limit_sel[t] != '0) && (used < limit_sel[t]);
      assign tcount[t]  = count_ff;

      always_ff @(posedge clock) begin
         if (take) begin
            mem[slot] <= {key_sel[t], used + LIMIT_BITS'(1)};
         end
         rdata_ff <= mem[idx_ff[AW-1:0]];
      end

      always_ff @(posedge clock) begin
         if (reset || clear_all || clear_win) begin
            valid_ff <= '0;
            count_ff <= '0;
         end else if (take && !hit_ff) begin
            valid_ff[slot] <= 1'b1;
            count_ff       <= count_ff + (AW + 1)'(1);
         end
      end

      always_ff @(posedge clock) begin
         if (reset || cmd.scan_start) begin
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
         end else if (rd_vld_ff && !hit_ff) begin
            if (valid_ff[rd_idx_ff]) begin
               if (rdata_ff[MW-1:LIMIT_BITS] == key_sel[t]) begin
                  hit_ff      <= 1'b1;
                  hit_slot_ff <= rd_idx_ff;
                  hit_cnt_ff  <= rdata_ff[LIMIT_BITS-1:0];
               end
            end else if (!free_ff) begin
               free_ff      <= 1'b1;
               free_slot_ff <= rd_idx_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cls_mem[cls_idx] <= cls_used + LIMIT_BITS'(1);
      end
      cls_rdata_ff <= cls_mem[cls_idx];
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all || clear_win) begin
         cls_valid_ff <= '0;
         cls_count_ff <= '0;
      end else if (take && !cls_valid_ff[cls_idx]) begin
         cls_valid_ff[cls_idx] <= 1'b1;
         cls_count_ff          <= cls_count_ff + (CAW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.scan_start) begin
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else if (cmd.scan_step && (idx_ff < (AW + 1)'(TABLE_DEPTH))) begin
         idx_ff    <= idx_ff + (AW + 1)'(1);
         rd_idx_ff <= idx_ff[AW-1:0];
         rd_vld_ff <= 1'b1;
      end else begin
         rd_vld_ff <= 1'b0;
      end
   end

   assign span      = {len, OVERLOAD_SHIFT'(0)};
   assign until_sum = {1'b0, req_ff.now_seconds} + (TIME_BITS + 1)'(span);
   assign until_sat = until_sum[TIME_BITS] ? '1 : until_sum[TIME_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset || clear_all) begin
         active_ff   <= '0;
         seen_ff     <= 1'b0;
         deadline_ff <= '0;
      end else begin
         if (cmd.window && !stale && (!seen_ff || clear_win)) begin
            active_ff <= quotient;
            seen_ff   <= 1'b1;
         end
         if (cmd.apply && (command_type'(req_ff.command) == CMD_OVERLOAD)
             && (until_sat > deadline_ff)) begin
            deadline_ff <= until_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear_all || clear_win) begin
         total_ff <= '0;
      end else if (take) begin
         total_ff <= total_ff + LIMIT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         admitted_ff <= 1'b0;
      end else if (take) begin
         admitted_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff   <= LIMIT_BITS'(1);
         total_limit_ff     <= '0;
         endpoint_limit_ff  <= '0;
         target_limit_ff    <= '0;
         custodian_limit_ff <= '0;
         class_limit_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_WINDOW_LENGTH:   window_length_ff   <= csr_write_data;
            REG_TOTAL_LIMIT:     total_limit_ff     <= csr_write_data;
            REG_ENDPOINT_LIMIT:  endpoint_limit_ff  <= csr_write_data;
            REG_TARGET_LIMIT:    target_limit_ff    <= csr_write_data;
            REG_CUSTODIAN_LIMIT: custodian_limit_ff <= csr_write_data;
            REG_CLASS_LIMIT:     class_limit_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign tracked_sum = SW'(tcount[0]) + SW'(tcount[1]) + SW'(tcount[2]) + SW'(cls_count_ff);
   assign tracked     = (tracked_sum > SW'(TRACKED_MAX)) ? TRACKED_MAX
                                                         : tracked_sum[TRACKED_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.respond) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.respond) begin
         rsp_ff.admitted        <= admitted_ff;
         rsp_ff.overload_active <= overload_now;
         rsp_ff.tracked_keys    <= tracked;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign status.div_done     = !div_busy;
   assign status.window_stale = stale;
   assign status.scan_done    = (idx_ff == (AW + 1)'(TABLE_DEPTH)) && !rd_vld_ff;
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

endmodule

// File: hw/rtl/mkwrl_ctrl.sv
// Controller state machine sequencing divide, window update, table scan and response.
module mkwrl_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [1:0]               req_command,
   output logic                     req_ready,
   input  mkwrl_pkg::dp_status_type status,
   output mkwrl_pkg::ctrl_cmd_type  cmd
);
   import mkwrl_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (command_type'(req_command)) inside
                  CMD_ADMIT:                  state_in = ST_START;
                  CMD_OVERLOAD, CMD_CLEAR:    state_in = ST_APPLY;
                  default:                    state_in = ST_RESPOND;
               endcase
            end
         end
         ST_START:   state_in = ST_DIVIDE;
         ST_DIVIDE:  if (status.div_done) state_in = ST_WINDOW;
         ST_WINDOW:  state_in = status.window_stale ? ST_RESPOND : ST_SCAN;
         ST_SCAN:    if (status.scan_done) state_in = ST_CHECK;
         ST_CHECK:   state_in = ST_RESPOND;
         ST_APPLY:   state_in = ST_RESPOND;
         ST_RESPOND: if (status.rsp_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_START:  cmd.div_start = 1'b1;
         ST_DIVIDE: ;
         ST_WINDOW: begin
            cmd.window     = 1'b1;
            cmd.scan_start = 1'b1;
         end
         ST_SCAN:    cmd.scan_step = 1'b1;
         ST_CHECK:   cmd.check     = 1'b1;
         ST_APPLY:   cmd.apply     = 1'b1;
         ST_RESPOND: cmd.respond   = status.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/mkwrl_checker.sv
// Port-level checks for the rate limiter, bound to the top level.
module mkwrl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input mkwrl_pkg::rsp_payload_type  rsp_data
);

   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("not idle after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while busy");

   a_result_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result issued while request still in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind multi_key_window_rate_limiter mkwrl_checker u_mkwrl_checker (.*);

// File: tb/tb_multi_key_window_rate_limiter.sv
// Testbench for the multi-key window rate limiter: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module tb_multi_key_window_rate_limiter;
   import mkwrl_pkg::*;

   localparam int DEPTH       = TABLE_DEPTH_DEFAULT;
   localparam int CLASSES     = CLASS_ENTRIES_DEFAULT;
   localparam int RANDOM_ITEMS = 1250;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE      = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [REG_INDEX_BITS-1:0] csr_index = '0;
   logic [LIMIT_BITS-1:0] csr_write_data = '0;

   multi_key_window_rate_limiter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // limiter state mirror
   logic [31:0] win_len, lim_total, lim_ep, lim_tg, lim_cu, lim_cls;
   logic [63:0] cur_window, deadline;
   logic        seen_window;
   logic [31:0] admitted_total;
   logic [63:0] ep_key [DEPTH], tg_key [DEPTH], cu_key [DEPTH];
   logic [31:0] ep_cnt [DEPTH], tg_cnt [DEPTH], cu_cnt [DEPTH], cls_cnt [CLASSES];
   bit          ep_vld [DEPTH], tg_vld [DEPTH], cu_vld [DEPTH], cls_vld [CLASSES];

   rsp_payload_type pending_rsp [$];
   int  fail_count = 0;
   int  cycle_count = 0;
   bit  quiet = 1'b0;
   bit  reset_done = 1'b0;

   function automatic void wipe_counts();
      admitted_total = 0;
      for (int i = 0; i < DEPTH; i++) begin
         ep_vld[i] = 0; tg_vld[i] = 0; cu_vld[i] = 0;
         ep_cnt[i] = 0; tg_cnt[i] = 0; cu_cnt[i] = 0;
      end
      for (int i = 0; i < CLASSES; i++) begin
         cls_vld[i] = 0; cls_cnt[i] = 0;
      end
   endfunction

   function automatic void wipe_all();
      wipe_counts();
      cur_window = 0; seen_window = 0; deadline = 0;
   endfunction

   function automatic int find_slot(ref logic [63:0] keys [DEPTH], ref bit vld [DEPTH],
                                    input logic [63:0] k, output bit hit);
      int free_slot;
      free_slot = -1;
      hit = 0;
      for (int i = 0; i < DEPTH; i++) begin
         if (vld[i]) begin
            if (keys[i] == k) begin
               hit = 1;
               return i;
            end
         end else if (free_slot < 0) free_slot = i;
      end
      return free_slot;
   endfunction

   function automatic bit key_ok(ref logic [63:0] keys [DEPTH], ref logic [31:0] cnt [DEPTH],
                                 ref bit vld [DEPTH], input logic [63:0] k,
                                 input logic [31:0] lim);
      bit hit;
      int s;
      s = find_slot(keys, vld, k, hit);
      if (s < 0 || lim == 0) return 0;
      return (hit ? cnt[s] : 32'd0) < lim;
   endfunction

   function automatic void key_bump(ref logic [63:0] keys [DEPTH], ref logic [31:0] cnt [DEPTH],
                                    ref bit vld [DEPTH], input logic [63:0] k);
      bit hit;
      int s;
      s = find_slot(keys, vld, k, hit);
      if (s < 0) return;
      if (!hit) begin
         keys[s] = k; cnt[s] = 0; vld[s] = 1;
      end
      cnt[s]++;
   endfunction

   function automatic bit try_admit(req_payload_type r);
      logic [63:0] len, w;
      logic [31:0] eff;
      len = (win_len == 0) ? 64'd1 : {32'd0, win_len};
      w = r.now_seconds / len;
      if (!seen_window) begin
         cur_window = w; seen_window = 1;
      end else if (w < cur_window) return 0;
      else if (w > cur_window) begin
         wipe_counts();
         cur_window = w;
      end
      if (deadline > r.now_seconds) begin
         eff = lim_total >> 2;
         if (eff < 1) eff = 1;
      end else eff = lim_total;
      if (admitted_total >= eff) return 0;
      if (!key_ok(ep_key, ep_cnt, ep_vld, r.endpoint_id, lim_ep)) return 0;
      if (!key_ok(tg_key, tg_cnt, tg_vld, r.target_id, lim_tg)) return 0;
      if (!key_ok(cu_key, cu_cnt, cu_vld, r.custodian_id, lim_cu)) return 0;
      if (int'(r.class_id) >= CLASSES || lim_cls == 0) return 0;
      if (cls_vld[r.class_id] && cls_cnt[r.class_id] >= lim_cls) return 0;
      admitted_total++;
      key_bump(ep_key, ep_cnt, ep_vld, r.endpoint_id);
      key_bump(tg_key, tg_cnt, tg_vld, r.target_id);
      key_bump(cu_key, cu_cnt, cu_vld, r.custodian_id);
      if (!cls_vld[r.class_id]) begin
         cls_vld[r.class_id] = 1; cls_cnt[r.class_id] = 0;
      end
      cls_cnt[r.class_id]++;
      return 1;
   endfunction

   function automatic rsp_payload_type predict_decision(req_payload_type r);
      rsp_payload_type o;
      logic [63:0] len, span, ovl_end;
      int n;
      o = '0;
      case (command_type'(r.command))
         CMD_ADMIT: o.admitted = try_admit(r);
         CMD_OVERLOAD: begin
            len = (win_len == 0) ? 64'd1 : {32'd0, win_len};
            span = len * 64'd4;
            ovl_end = (r.now_seconds > ~64'd0 - span) ? ~64'd0 : r.now_seconds + span;
            if (ovl_end > deadline) deadline = ovl_end;
         end
         CMD_CLEAR: wipe_all();
         default: ;
      endcase
      n = 0;
      for (int i = 0; i < DEPTH; i++) n += ep_vld[i] + tg_vld[i] + cu_vld[i];
      for (int i = 0; i < CLASSES; i++) n += cls_vld[i];
      if (n > 511) n = 511;
      o.overload_active = deadline > r.now_seconds;
      o.tracked_keys = n[TRACKED_BITS-1:0];
      return o;
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      fail_count++;
   endtask

   // response sink with random stall bursts
   always @(posedge clock) begin
      rsp_payload_type want;
      cycle_count <= cycle_count + 1;
      if (reset_done && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) report_mismatch("unexpected response");
         else begin
            want = pending_rsp.pop_front();
            if (rsp_data.admitted !== want.admitted)
               report_mismatch($sformatf("admitted %0b want %0b", rsp_data.admitted,
                                         want.admitted));
            if (rsp_data.overload_active !== want.overload_active)
               report_mismatch($sformatf("overload_active %0b want %0b",
                                         rsp_data.overload_active, want.overload_active));
            if (rsp_data.tracked_keys !== want.tracked_keys)
               report_mismatch($sformatf("tracked_keys %0d want %0d", rsp_data.tracked_keys,
                                         want.tracked_keys));
         end
      end
   end

   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!quiet && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 4);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else rsp_ready <= 1'b1;
      end
   end

   initial begin
      if (cycle_count >= 0) begin
         wait (cycle_count >= CYCLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // hold valid across back-to-back transfers; drop it only for an idle burst
   task automatic send_item(req_payload_type r, bit check_fixed, rsp_payload_type fixed);
      rsp_payload_type got;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      got = predict_decision(r);
      if (check_fixed && got != fixed)
         report_mismatch($sformatf("predictor %h disagrees with table %h", got, fixed));
      pending_rsp.insert(pending_rsp.size(), got);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(reg_index_type idx, logic [31:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      case (idx)
         REG_WINDOW_LENGTH:   win_len = v;
         REG_TOTAL_LIMIT:     lim_total = v;
         REG_ENDPOINT_LIMIT:  lim_ep = v;
         REG_TARGET_LIMIT:    lim_tg = v;
         REG_CUSTODIAN_LIMIT: lim_cu = v;
         REG_CLASS_LIMIT:     lim_cls = v;
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_all(logic [31:0] wl, logic [31:0] t, logic [31:0] k, logic [31:0] c);
      write_reg(REG_WINDOW_LENGTH, wl);
      write_reg(REG_TOTAL_LIMIT, t);
      write_reg(REG_ENDPOINT_LIMIT, k);
      write_reg(REG_TARGET_LIMIT, k);
      write_reg(REG_CUSTODIAN_LIMIT, k);
      write_reg(REG_CLASS_LIMIT, c);
      csr_write_enable <= 1'b0;
   endtask

   typedef struct {
      command_type cmd;
      logic [63:0] now;
      logic [63:0] ep;
      logic [7:0]  cls;
      bit          fixed;
      bit          adm;
      bit          ovl;
      int          trk;
   } dir_row_type;

   function automatic req_payload_type make_req(command_type c, logic [63:0] now,
                                                logic [63:0] ep, logic [63:0] tg,
                                                logic [63:0] cu, logic [7:0] cls);
      req_payload_type r;
      r.command = c; r.now_seconds = now; r.endpoint_id = ep;
      r.target_id = tg; r.custodian_id = cu; r.class_id = cls;
      return r;
   endfunction

   function automatic logic [63:0] pick_key(int pool);
      if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
      return 64'(($urandom_range(0, pool - 1)) * 64'h9E37_79B9_7F4A_7C15);
   endfunction

   initial begin
      dir_row_type rows [$];
      rsp_payload_type fx;
      req_payload_type r;
      logic [63:0] t;
      int pool, phase;
      wipe_all();
      win_len = 1; lim_total = 0; lim_ep = 0; lim_tg = 0; lim_cu = 0; lim_cls = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      reset_done = 1'b1;
      @(posedge clock);

      // defaults: zero limits refuse everything
      rows.insert(rows.size(), dir_row_type'{CMD_STATUS,   64'd0,  64'd0, 8'd0, 1, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_ADMIT,    64'd5,  64'd1, 8'd0, 1, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_OVERLOAD, 64'd5,  64'd1, 8'd0, 1, 0, 1, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_ADMIT,    64'd6,  64'd1, 8'd3, 1, 0, 1, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_CLEAR,    64'd6,  64'd0, 8'd0, 1, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_OVERLOAD, ~64'd0, 64'd0, 8'd0, 1, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_OVERLOAD, ~64'd3, 64'd0, 8'd0, 1, 0, 1, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_CLEAR,    64'd0,  64'd0, 8'd0, 1, 0, 0, 0});
      foreach (rows[i]) begin
         fx = '0;
         fx.admitted = rows[i].adm; fx.overload_active = rows[i].ovl;
         fx.tracked_keys = TRACKED_BITS'(rows[i].trk);
         send_item(make_req(rows[i].cmd, rows[i].now, rows[i].ep, ~rows[i].ep,
                            rows[i].ep, rows[i].cls), rows[i].fixed, fx);
      end
      drain();

      write_all(32'd0, 32'd3, 32'd2, 32'd1);
      rows.delete();
      rows.insert(rows.size(), dir_row_type'{CMD_ADMIT,    64'd100, 64'd7,  8'd255, 0, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_ADMIT,    64'd100, 64'd7,  8'd255, 0, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_ADMIT,    64'd100, 64'd8,  8'd1,   0, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_ADMIT,    64'd100, 64'd9,  8'd2,   0, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_ADMIT,    64'd99,  64'd9,  8'd2,   0, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_ADMIT,    64'd101, 64'd9,  8'd2,   0, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_OVERLOAD, 64'd101, 64'd0,  8'd0,   0, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_ADMIT,    64'd102, 64'd1,  8'd4,   0, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_ADMIT,    64'd102, 64'd2,  8'd5,   0, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_STATUS,   64'd102, 64'd0,  8'd0,   0, 0, 0, 0});
      rows.insert(rows.size(), dir_row_type'{CMD_ADMIT,    64'd200, ~64'd0, 8'd0,   0, 0, 0, 0});
      foreach (rows[i])
         send_item(make_req(rows[i].cmd, rows[i].now, rows[i].ep, rows[i].ep ^ 64'h55,
                            rows[i].ep, rows[i].cls), 0, '0);
      drain();

      // fill tables to the brim within one window
      write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(make_req(CMD_CLEAR, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0), 0, '0);
      for (int i = 0; i < DEPTH + 4; i++)
         send_item(make_req(CMD_ADMIT, 64'd10, {$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, 8'(i)), 0, '0);
      drain();

      t = 0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 150 == 0) begin
            drain();
            phase = n / 150;
            case (phase % 4)
               0: write_all($urandom_range(0, 5), $urandom_range(0, 12),
                            $urandom_range(1, 4), $urandom_range(1, 5));
               1: write_all($urandom_range(1, 100), $urandom_range(1, 40),
                            $urandom_range(0, 3), $urandom_range(0, 3));
               2: write_all($urandom, $urandom, $urandom, $urandom);
               default: write_all(32'hFFFF_FFFF, $urandom_range(0, 2000),
                                  $urandom_range(2, 9), $urandom_range(2, 9));
            endcase
            pool = (phase % 2) ? 6 : 80;
            if (phase % 3 == 0) t = {$urandom, $urandom};
         end
         if (n > RANDOM_ITEMS - 120) quiet = 1'b1;
         case ($urandom_range(0, 19))
            0: t = t - $urandom_range(0, 50);
            1, 2: t = t + $urandom_range(0, 3 * (win_len + 1));
            3: t = {$urandom, $urandom};
            default: t = t + $urandom_range(0, 1);
         endcase
         r = make_req(CMD_ADMIT, t, pick_key(pool), pick_key(pool), pick_key(pool),
                      $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'($urandom_range(0, 7)));
         case ($urandom_range(0, 39))
            0: r.command = CMD_CLEAR;
            1, 2: r.command = CMD_OVERLOAD;
            3, 4: r.command = CMD_STATUS;
            default: ;
         endcase
         send_item(r, 0, '0);
      end
      drain();
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
